>>> hw/rtl/fir27_pkg.sv
// Shared constants and coefficient quantizer for the 27-tap FIR filter.
`default_nettype none

package fir27_pkg;

    localparam int TAPS_DEF           = 27;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 15;

    localparam int OUT_BITS = 17;
    localparam int OUT_MAX  = 2 ** (OUT_BITS - 1) - 1;
    localparam int OUT_MIN  = -(2 ** (OUT_BITS - 1));

    localparam int    COEF_COUNT = 27;
    localparam int    COEF_HALF  = 14;
    localparam longint NanoScale = 64'sd1000000000;
    localparam longint NanoHalf  = 64'sd500000000;

    // left half of the symmetric set, units of 1e-9
    localparam longint COEF_NANO [COEF_HALF] = '{
        -64'sd1817133,   -64'sd10309430,  -64'sd14860920, -64'sd6554923,
        64'sd5310618,    64'sd0,          -64'sd19610280, -64'sd12773020,
        64'sd52648020,   64'sd137093600,  64'sd142650100, 64'sd17073880,
        -64'sd163988400, 64'sd750000000
    };

    // round-half-away quantization of tap idx to frac fraction bits
    function automatic longint coef_q(input int idx, input int frac);
        int     k;
        longint nano;
        longint mag;
        longint q;
        if (idx >= COEF_COUNT) begin
            return 64'sd0;
        end
        k    = (idx < COEF_HALF) ? idx : (COEF_COUNT - 1 - idx);
        nano = COEF_NANO[k];
        mag  = (nano < 0) ? -nano : nano;
        q    = ((mag <<< frac) + NanoHalf) / NanoScale;
        return (nano < 0) ? -q : q;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fir27_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module fir27_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 27
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/fir_filter_27_tap.sv
// Top level: direct-form FIR filter with one shared multiply-accumulate unit.
//
//  channel | ports                         | word
//  --------+-------------------------------+---------------------------
//  input   | s_valid s_ready s_sample      | one signed audio sample
//  result  | m_valid m_ready m_filtered    | one filtered sample
//
// A sample is written to the delay-line RAM when accepted; once the delay
// line holds TAPS samples each sample is then filtered by TAPS reads of the
// RAM through one multiplier and one accumulator, then pipeline and rounding.
// The result register lets the next sample enter while a result waits.
// aresetn (synchronous) clears write pointer, fill count and control; the RAM
// needs no clearing. A stalled result only holds the block in its last step.
`default_nettype none

module fir_filter_27_tap #(
    parameter int TAPS           = fir27_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS    = fir27_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = fir27_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]         s_sample,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [fir27_pkg::OUT_BITS-1:0]      m_filtered
);

    localparam int AW     = $clog2(TAPS);
    localparam int FW     = $clog2(TAPS + 1);
    localparam int CW     = COEF_FRAC_BITS + 1;
    localparam int PW     = SAMPLE_BITS + CW;
    localparam int ACC_W  = PW + $clog2(TAPS);
    localparam int OW     = fir27_pkg::OUT_BITS;

    localparam logic [AW-1:0] LAST_IDX = AW'(TAPS - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(TAPS);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(fir27_pkg::OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(fir27_pkg::OUT_MIN);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]  wp_reg, wp_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]  rd_idx_reg;
    logic           rd_vld_reg, rd_vld_next;
    logic           mul_vld_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic           m_valid_reg, m_valid_next;
    logic signed [OW-1:0]    m_filtered_reg, m_filtered_next;

    logic                         accept;
    logic [SAMPLE_BITS-1:0]       ram_rdata;
    logic signed [CW-1:0]         coef_tab [TAPS];
    logic signed [ACC_W-1:0]      shifted;
    logic signed [ACC_W-1:0]      rounded;
    logic                         frac_nz;

    for (genvar g = 0; g < TAPS; g++) begin : g_coef
        localparam longint CQ = fir27_pkg::coef_q(g, COEF_FRAC_BITS);
        assign coef_tab[g] = CW'(CQ);
    end

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

    fir27_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_line (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (s_sample),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // truncate toward zero: floor, then bump negatives with a remainder
    assign frac_nz = |acc_reg[COEF_FRAC_BITS-1:0];
    assign shifted = acc_reg >>> COEF_FRAC_BITS;
    assign rounded = shifted + ACC_W'(acc_reg[ACC_W-1] && frac_nz);

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        rd_ptr_next     = rd_ptr_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg;
        m_filtered_next = m_filtered_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (mul_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    wp_next     = (wp_reg == LAST_IDX) ? '0 : wp_reg + AW'(1);
                    fill_next   = (fill_reg == FULL_CNT) ? fill_reg : fill_reg + FW'(1);
                    rd_ptr_next = wp_reg;
                    cnt_next    = '0;
                    acc_next    = '0;
                    if (fill_reg >= FW'(TAPS - 1)) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                rd_vld_next = 1'b1;
                rd_ptr_next = (rd_ptr_reg == '0) ? LAST_IDX : rd_ptr_reg - AW'(1);
                cnt_next    = cnt_reg + AW'(1);
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mul_vld_reg && !rd_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    priority if (rounded > SAT_HI) begin
                        m_filtered_next = OW'(SAT_HI);
                    end else if (rounded < SAT_LO) begin
                        m_filtered_next = OW'(SAT_LO);
                    end else begin
                        m_filtered_next = OW'(rounded);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            fill_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            rd_vld_reg  <= rd_vld_next;
            mul_vld_reg <= rd_vld_reg;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg     <= rd_ptr_next;
        cnt_reg        <= cnt_next;
        rd_idx_reg     <= cnt_reg;
        prod_reg       <= $signed(ram_rdata) * coef_tab[rd_idx_reg];
        acc_reg        <= acc_next;
        m_filtered_reg <= m_filtered_next;
    end

    a_mul_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |=> mul_vld_reg)
        else $error("product stage did not follow a RAM read");

    a_no_result_unfilled: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && fill_reg < FW'(TAPS - 1)) |=> state_reg == ST_IDLE)
        else $error("filter started before the delay line was full");

    a_result_only_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> fill_reg == FULL_CNT)
        else $error("result given with an unfilled delay line");

    a_drain_no_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN || state_reg == ST_DONE) |=> !rd_vld_reg)
        else $error("RAM read issued after the last tap");

endmodule

`default_nettype wire

>>> tb/sv/fir_filter_27_tap_test.sv
// Self-checking testbench for the 27-tap direct-form FIR filter.
`timescale 1ns / 1ps

module fir_filter_27_tap_test;

    localparam int TAPS        = fir27_pkg::TAPS_DEF;
    localparam int SBITS       = fir27_pkg::SAMPLE_BITS_DEF;
    localparam int FRAC        = fir27_pkg::COEF_FRAC_BITS_DEF;
    localparam int OBITS       = fir27_pkg::OUT_BITS;
    localparam int CHUNKS      = 4;
    localparam int CHUNK_ITEMS = 300;
    localparam int HOLD_AT     = 650;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 20;

    localparam logic signed [SBITS-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SBITS-1:0] SAMPLE_MIN = 16'sh8000;

    // left half of the symmetric tap set, units of 1e-9
    localparam longint HALF_NANO [14] = '{
        -1817133, -10309430, -14860920, -6554923, 5310618, 0,
        -19610280, -12773020, 52648020, 137093600, 142650100,
        17073880, -163988400, 750000000
    };

    localparam logic signed [SBITS-1:0] DIRECTED [20] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
        16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh0F0F,
        16'shF0F0, 16'sh4000, 16'shC000, 16'sh7FFE, 16'sh8001,
        16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0002
    };

    typedef enum int {
        MIX_UNIFORM, MIX_RAIL, MIX_PEAK_HIGH, MIX_PEAK_LOW, MIX_SMALL, MIX_IMPULSE
    } mix_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_valid  = 1'b0;
    logic                    s_ready;
    logic signed [SBITS-1:0] s_sample = '0;
    logic                    m_valid;
    logic                    m_ready  = 1'b0;
    logic signed [OBITS-1:0] m_filtered;

    logic signed [SBITS-1:0] sample_queue[$];
    logic signed [OBITS-1:0] filtered_expect[$];
    logic signed [OBITS-1:0] want_filtered;

    longint                  tap_coef [TAPS];
    logic signed [SBITS-1:0] history [TAPS];
    int                      head_slot;
    int                      fill_level;

    int  samples_taken = 0;
    int  pushed_total  = 0;
    int  results_seen  = 0;
    int  errors        = 0;
    int  hold_left     = 0;
    int  peak_seen     = 0;
    int  floor_seen    = 0;
    bit  idle_en       = 1'b0;

    fir_filter_27_tap dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

    always #1 aclk = ~aclk;

    // push a sample into the delay line, queue the filtered word once full
    function automatic void filter_sample(input logic signed [SBITS-1:0] x);
        longint acc;
        longint res;
        int     idx;
        history[head_slot] = x;
        head_slot = (head_slot == TAPS - 1) ? 0 : head_slot + 1;
        if (fill_level < TAPS) fill_level++;
        if (fill_level < TAPS) return;
        acc = 0;
        for (int i = 0; i < TAPS; i++) begin
            idx = head_slot + TAPS - 1 - i;
            if (idx >= TAPS) idx -= TAPS;
            acc += longint'(history[idx]) * tap_coef[i];
        end
        if (acc < 0) res = -((-acc) >>> FRAC);
        else res = acc >>> FRAC;
        if (res > fir27_pkg::OUT_MAX) res = fir27_pkg::OUT_MAX;
        if (res < fir27_pkg::OUT_MIN) res = fir27_pkg::OUT_MIN;
        filtered_expect.push_back(res[OBITS-1:0]);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                filter_sample(s_sample);
                samples_taken++;
            end
            if (!s_valid || s_ready) begin
                if (sample_queue.size() > 0 &&
                    !(idle_en && $urandom_range(99) < IDLE_PCT)) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_filtered > peak_seen) peak_seen = m_filtered;
                if (m_filtered < floor_seen) floor_seen = m_filtered;
                if (filtered_expect.size() == 0) begin
                    $display("%0t: unexpected word, filtered=%0d", $time, m_filtered);
                    errors++;
                end else begin
                    want_filtered = filtered_expect.pop_front();
                    if (m_filtered !== want_filtered) begin
                        $display("%0t: filtered mismatch, expected %0d, got %0d",
                                 $time, want_filtered, m_filtered);
                        errors++;
                    end
                end
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("%0t: run did not complete in time", $time);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        longint nano;
        longint mag;
        longint q;
        int     k;
        int     n;
        int     pick;
        mix_t   mode;
        logic signed [SBITS-1:0] v;

        for (int i = 0; i < TAPS; i++) begin
            k    = (i < 14) ? i : (TAPS - 1 - i);
            nano = HALF_NANO[k];
            mag  = (nano < 0) ? -nano : nano;
            q    = ((mag << FRAC) + 64'd500000000) / 64'd1000000000;
            tap_coef[i] = (nano < 0) ? -q : q;
        end
        head_slot  = 0;
        fill_level = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) sample_queue.push_back(DIRECTED[i]);
        pushed_total += $size(DIRECTED);

        for (int c = 0; c < CHUNKS; c++) begin
            idle_en = (c != 0);
            n = 0;
            while (n < CHUNK_ITEMS) begin
                k    = $urandom_range(8);
                mode = (k < 4) ? MIX_UNIFORM : mix_t'(k - 3);
                pick = $urandom_range(TAPS - 1);
                for (int j = 0; j < TAPS && n < CHUNK_ITEMS; j++) begin
                    case (mode)
                        MIX_RAIL: begin
                            case ($urandom_range(3))
                                0: v = SAMPLE_MAX;
                                1: v = SAMPLE_MIN;
                                2: v = '0;
                                default: v = '1;
                            endcase
                        end
                        MIX_PEAK_HIGH: v = (tap_coef[j] >= 0) ? SAMPLE_MAX : SAMPLE_MIN;
                        MIX_PEAK_LOW:  v = (tap_coef[j] >= 0) ? SAMPLE_MIN : SAMPLE_MAX;
                        MIX_SMALL:     v = SBITS'($urandom_range(16) - 8);
                        MIX_IMPULSE: begin
                            if (j == pick) v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                            else v = '0;
                        end
                        default:       v = SBITS'($urandom);
                    endcase
                    sample_queue.push_back(v);
                    n++;
                end
            end
            pushed_total += CHUNK_ITEMS;
            // sender pauses here until the filter has drained
            while (samples_taken != pushed_total || filtered_expect.size() != 0)
                @(posedge aclk);
        end

        repeat (TAPS + 10) @(posedge aclk);
        if (filtered_expect.size() != 0) begin
            $display("%0t: %0d filtered words never arrived", $time, filtered_expect.size());
            errors++;
        end

        $display("Fed %0d samples (directed, rail, peak and impulse runs, random), %s %0d words",
                 samples_taken, "checked", results_seen);
        $display("Output span seen %0d..%0d, %0d mismatches", floor_seen, peak_seen, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
